@@ design/dpc_pkg.sv @@
// shared constants and helper functions for the density peak clustering engine
package dpc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int RHO_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SAMPLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RHO_MIN     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_MIN   = 2'd3;

  localparam logic [6:0]       NUM_SAMPLES_RST = 7'd64;
  localparam logic [RHO_W-1:0] RHO_MIN_RST     = 16'd256;
  localparam logic [15:0]      DELTA_MIN_RST   = 16'd26;

  localparam logic [RHO_W-1:0] RHO_ONE  = 16'd256;
  localparam logic [4:0]       GAUSS_LAST = 5'd20;

  // floor(x / 100) as (x * QUANT_RECIP) >> QUANT_SHIFT, exact for x below 2^13
  localparam int QUANT_RECIP = 5243;
  localparam int QUANT_SHIFT = 19;
  localparam int QUANT_BIAS  = 50;

  function automatic logic [RHO_W-1:0] gauss_weight(input logic [4:0] q);
    logic [RHO_W-1:0] w;
    case (q)
      5'd0:    w = 16'd256;
      5'd1:    w = 16'd252;
      5'd2:    w = 16'd240;
      5'd3:    w = 16'd222;
      5'd4:    w = 16'd199;
      5'd5:    w = 16'd173;
      5'd6:    w = 16'd146;
      5'd7:    w = 16'd119;
      5'd8:    w = 16'd94;
      5'd9:    w = 16'd72;
      5'd10:   w = 16'd54;
      5'd11:   w = 16'd39;
      5'd12:   w = 16'd27;
      5'd13:   w = 16'd18;
      5'd14:   w = 16'd12;
      5'd15:   w = 16'd8;
      5'd16:   w = 16'd5;
      5'd17:   w = 16'd3;
      5'd18:   w = 16'd2;
      5'd19:   w = 16'd1;
      default: w = 16'd0;
    endcase
    return w;
  endfunction

  function automatic logic [RHO_W-1:0] sat_add(input logic [RHO_W-1:0] a,
                                               input logic [RHO_W-1:0] b);
    logic [RHO_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[RHO_W] ? {RHO_W{1'b1}} : s[RHO_W-1:0];
  endfunction

endpackage

@@ design/dpc_ram.sv @@
// generic single write port ram with one registered read port
module dpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/density_peak_clustering.sv @@
// density peak clustering engine: matrix load, sequencer and result output
//
// Distance matrix elements are taken one per cycle while idle and written to the
// distance store. The item flagged last_element starts a run and input stalls until
// all n results have been taken. A run is a sequence of passes, each step using the
// single read port of the memory involved: cutoff search, density (cutoff kernel, or
// Gaussian kernel with one threshold compare per cycle), density ranking, nearest
// denser search, labelling, halo when more than one cluster is found, then output of
// one result at a time, each held while out_stall is high.
// No clearing pass is needed after reset.
module density_peak_clustering #(
  parameter int MAX_SAMPLES = 64,
  parameter int DIST_BITS   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [DIST_BITS-1:0]                   in_distance,
  input  logic                                   in_last_element,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [$clog2(MAX_SAMPLES)-1:0]         out_sample_index,
  output logic signed [$clog2(MAX_SAMPLES):0]    out_cluster_id,
  output logic                                   out_is_center,
  output logic                                   out_is_core,
  output logic [$clog2(MAX_SAMPLES+1)-1:0]       out_cluster_count,
  output logic                                   out_last_result,
  input  logic                                   cfg_wr_en,
  input  logic [dpc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [dpc_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
  import dpc_pkg::*;

  localparam int IW    = $clog2(MAX_SAMPLES);
  localparam int CW    = $clog2(MAX_SAMPLES + 1);
  localparam int LW    = IW + 1;
  localparam int DEPTH = MAX_SAMPLES * MAX_SAMPLES;
  localparam int SAW   = $clog2(DEPTH);
  localparam int TW    = DIST_BITS + 6;
  localparam int XW    = 2 * CW + 6;
  localparam int PW    = XW + 13;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  typedef enum logic [39:0] {
    ST_IDLE   = 40'd1 << 0,
    ST_PREP   = 40'd1 << 1,
    ST_POS    = 40'd1 << 2,
    ST_QINIT  = 40'd1 << 3,
    ST_Q_MID  = 40'd1 << 4,
    ST_Q_RD   = 40'd1 << 5,
    ST_Q_EX   = 40'd1 << 6,
    ST_Q_UPD  = 40'd1 << 7,
    ST_D_ROW  = 40'd1 << 8,
    ST_D_RD   = 40'd1 << 9,
    ST_D_EX   = 40'd1 << 10,
    ST_D_Q    = 40'd1 << 11,
    ST_R_RDI  = 40'd1 << 12,
    ST_R_LDI  = 40'd1 << 13,
    ST_R_RD   = 40'd1 << 14,
    ST_R_EX   = 40'd1 << 15,
    ST_S_RDO  = 40'd1 << 16,
    ST_S_LDO  = 40'd1 << 17,
    ST_S_RDJ  = 40'd1 << 18,
    ST_S_RDD  = 40'd1 << 19,
    ST_S_EX   = 40'd1 << 20,
    ST_S_TOP  = 40'd1 << 21,
    ST_S_TOPW = 40'd1 << 22,
    ST_L_RD   = 40'd1 << 23,
    ST_L_EX   = 40'd1 << 24,
    ST_P_RDO  = 40'd1 << 25,
    ST_P_RDL  = 40'd1 << 26,
    ST_P_EX   = 40'd1 << 27,
    ST_P_WR   = 40'd1 << 28,
    ST_H_CLR  = 40'd1 << 29,
    ST_H_RDI  = 40'd1 << 30,
    ST_H_LDI  = 40'd1 << 31,
    ST_H_RDJ  = 40'd1 << 32,
    ST_H_EX   = 40'd1 << 33,
    ST_H_BI   = 40'd1 << 34,
    ST_H_BJ   = 40'd1 << 35,
    ST_O_RD   = 40'd1 << 36,
    ST_O_RDB  = 40'd1 << 37,
    ST_O_EX   = 40'd1 << 38,
    ST_O_WAIT = 40'd1 << 39
  } state_t;

  state_t state_r, state_nxt;

  logic [6:0]           num_samples_r;
  logic                 kernel_mode_r;
  logic [RHO_W-1:0]     rho_min_r;
  logic [15:0]          delta_min_r;
  logic [SAW-1:0]       lp_r;

  logic [CW-1:0]        n_r, n_nxt, i_r, i_nxt, j_r, j_nxt, r_r, r_nxt, ncl_r, ncl_nxt;
  logic [XW-1:0]        x_r, x_nxt;
  logic [SAW-1:0]       k_r, k_nxt, cnt_r, cnt_nxt;
  logic [DIST_BITS-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt, dc_r, dc_nxt;
  logic [DIST_BITS-1:0] d_r, d_nxt, sepv_r, sepv_nxt, best_r, best_nxt;
  logic [RHO_W-1:0]     acc_r, acc_nxt, di_r, di_nxt, avg_r, avg_nxt;
  logic [4:0]           q_r, q_nxt;
  logic [TW-1:0]        t_r, t_nxt;
  logic [IW-1:0]        si_r, si_nxt, o_r, o_nxt, pi_r, pi_nxt;
  logic [IW:0]          nbv_r, nbv_nxt;
  logic [LW-1:0]        li_r, li_nxt, lj_r, lj_nxt, lo_lab_r, lo_lab_nxt;
  logic                 cen_r, cen_nxt;

  logic                 ov_r, ov_nxt;
  logic [IW-1:0]        oidx_r, oidx_nxt;
  logic [LW-1:0]        olab_r, olab_nxt;
  logic                 ocen_r, ocen_nxt, ocore_r, ocore_nxt, olast_r, olast_nxt;

  logic                 in_acc;
  logic [SAW-1:0]       dist_raddr;
  logic [DIST_BITS-1:0] dist_rdata;
  logic                 dens_we, sep_we, nb_we, lab_we, ord_we, bord_we;
  logic [IW-1:0]        dens_waddr, sep_waddr, nb_waddr, lab_waddr, ord_waddr, bord_waddr;
  logic [IW-1:0]        dens_raddr, sep_raddr, nb_raddr, lab_raddr, ord_raddr, bord_raddr;
  logic [RHO_W-1:0]     dens_wdata, dens_rdata, bord_wdata, bord_rdata;
  logic [DIST_BITS-1:0] sep_wdata, sep_rdata;
  logic [IW:0]          nb_wdata, nb_rdata;
  logic [LW-1:0]        lab_wdata, lab_rdata;
  logic [IW-1:0]        ord_wdata, ord_rdata;

  logic [PW-1:0]        quant_prod;
  logic [TW-1:0]        d16;
  logic [RHO_W:0]       pair_sum;
  logic                 dens_center, sep_center;
  logic [6:0]           n_clamp;

  function automatic logic [SAW-1:0] daddr(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                           input logic [CW-1:0] n);
    logic [2*CW-1:0] p;
    p = (2*CW)'(a) * (2*CW)'(n) + (2*CW)'(b);
    return p[SAW-1:0];
  endfunction

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign quant_prod  = PW'(x_r) * PW'(QUANT_RECIP);
  assign d16         = TW'(d_r) << 4;
  assign pair_sum    = {1'b0, di_r} + {1'b0, dens_rdata};
  assign dens_center = dens_rdata > rho_min_r;
  assign sep_center  = 33'(sep_rdata) > 33'(delta_min_r);
  assign n_clamp     = (num_samples_r < 7'd2) ? 7'd2 :
                       (num_samples_r > 7'(MAX_SAMPLES)) ? 7'(MAX_SAMPLES) : num_samples_r;

  always_comb begin
    state_nxt  = state_r;
    n_nxt      = n_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    r_nxt      = r_r;
    ncl_nxt    = ncl_r;
    x_nxt      = x_r;
    k_nxt      = k_r;
    cnt_nxt    = cnt_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    dc_nxt     = dc_r;
    d_nxt      = d_r;
    sepv_nxt   = sepv_r;
    best_nxt   = best_r;
    acc_nxt    = acc_r;
    di_nxt     = di_r;
    avg_nxt    = avg_r;
    q_nxt      = q_r;
    t_nxt      = t_r;
    si_nxt     = si_r;
    o_nxt      = o_r;
    pi_nxt     = pi_r;
    nbv_nxt    = nbv_r;
    li_nxt     = li_r;
    lj_nxt     = lj_r;
    lo_lab_nxt = lo_lab_r;
    cen_nxt    = cen_r;
    ov_nxt     = ov_r;
    oidx_nxt   = oidx_r;
    olab_nxt   = olab_r;
    ocen_nxt   = ocen_r;
    ocore_nxt  = ocore_r;
    olast_nxt  = olast_r;

    dist_raddr = '0;
    dens_we = 1'b0; dens_waddr = i_r[IW-1:0]; dens_wdata = acc_r; dens_raddr = '0;
    sep_we  = 1'b0; sep_waddr  = si_r; sep_wdata = sepv_r; sep_raddr = '0;
    nb_we   = 1'b0; nb_waddr   = si_r; nb_wdata  = nbv_r;  nb_raddr  = '0;
    lab_we  = 1'b0; lab_waddr  = i_r[IW-1:0]; lab_wdata = '1; lab_raddr = '0;
    ord_we  = 1'b0; ord_waddr  = r_r[IW-1:0]; ord_wdata = i_r[IW-1:0]; ord_raddr = '0;
    bord_we = 1'b0; bord_waddr = li_r[IW-1:0]; bord_wdata = avg_r; bord_raddr = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_last_element) begin
          n_nxt     = CW'(n_clamp);
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        x_nxt     = XW'(n_r) * XW'(n_r - CW'(1)) + XW'(QUANT_BIAS);
        state_nxt = ST_POS;
      end
      ST_POS: begin
        k_nxt     = SAW'(quant_prod >> QUANT_SHIFT);
        state_nxt = ST_QINIT;
      end
      ST_QINIT: begin
        k_nxt     = (k_r == '0) ? '0 : k_r - SAW'(1);
        lo_nxt    = '0;
        hi_nxt    = DIST_MAX;
        state_nxt = ST_Q_MID;
      end
      ST_Q_MID: begin
        if (lo_r < hi_r) begin
          mid_nxt   = lo_r + ((hi_r - lo_r) >> 1);
          cnt_nxt   = '0;
          i_nxt     = '0;
          j_nxt     = CW'(1);
          state_nxt = ST_Q_RD;
        end else begin
          dc_nxt    = lo_r;
          i_nxt     = '0;
          state_nxt = ST_D_ROW;
        end
      end
      ST_Q_RD: begin
        dist_raddr = daddr(i_r, j_r, n_r);
        state_nxt  = ST_Q_EX;
      end
      ST_Q_EX: begin
        if (dist_rdata <= mid_r) cnt_nxt = cnt_r + SAW'(1);
        if (j_r + CW'(1) < n_r) begin
          j_nxt     = j_r + CW'(1);
          state_nxt = ST_Q_RD;
        end else if (i_r + CW'(2) < n_r) begin
          i_nxt     = i_r + CW'(1);
          j_nxt     = i_r + CW'(2);
          state_nxt = ST_Q_RD;
        end else begin
          state_nxt = ST_Q_UPD;
        end
      end
      ST_Q_UPD: begin
        if (cnt_r > k_r) hi_nxt = mid_r;
        else lo_nxt = mid_r + DIST_BITS'(1);
        state_nxt = ST_Q_MID;
      end
      ST_D_ROW: begin
        acc_nxt   = '0;
        j_nxt     = '0;
        state_nxt = ST_D_RD;
      end
      ST_D_RD: begin
        if (j_r == n_r) begin
          dens_we = 1'b1;
          i_nxt   = i_r + CW'(1);
          if (i_r + CW'(1) == n_r) begin
            i_nxt     = '0;
            state_nxt = ST_R_RDI;
          end else begin
            state_nxt = ST_D_ROW;
          end
        end else if (j_r == i_r) begin
          j_nxt = j_r + CW'(1);
        end else begin
          dist_raddr = (i_r < j_r) ? daddr(i_r, j_r, n_r) : daddr(j_r, i_r, n_r);
          state_nxt  = ST_D_EX;
        end
      end
      ST_D_EX: begin
        d_nxt     = dist_rdata;
        j_nxt     = j_r + CW'(1);
        state_nxt = ST_D_RD;
        if (dist_rdata != DIST_MAX) begin
          if (!kernel_mode_r) begin
            if (dist_rdata < dc_r) acc_nxt = sat_add(acc_r, RHO_ONE);
          end else begin
            j_nxt     = j_r;
            q_nxt     = '0;
            t_nxt     = TW'(dc_r);
            state_nxt = ST_D_Q;
          end
        end
      end
      ST_D_Q: begin
        if (dc_r == '0) begin
          acc_nxt   = sat_add(acc_r, gauss_weight((d_r == '0) ? 5'd0 : GAUSS_LAST));
          j_nxt     = j_r + CW'(1);
          state_nxt = ST_D_RD;
        end else if (q_r != GAUSS_LAST && d16 >= t_r) begin
          q_nxt = q_r + 5'd1;
          t_nxt = t_r + (TW'(dc_r) << 1);
        end else begin
          acc_nxt   = sat_add(acc_r, gauss_weight(q_r));
          j_nxt     = j_r + CW'(1);
          state_nxt = ST_D_RD;
        end
      end
      ST_R_RDI: begin
        dens_raddr = i_r[IW-1:0];
        state_nxt  = ST_R_LDI;
      end
      ST_R_LDI: begin
        di_nxt    = dens_rdata;
        j_nxt     = '0;
        r_nxt     = '0;
        state_nxt = ST_R_RD;
      end
      ST_R_RD: begin
        if (j_r == n_r) begin
          ord_we = 1'b1;
          i_nxt  = i_r + CW'(1);
          if (i_r + CW'(1) == n_r) begin
            best_nxt  = '0;
            r_nxt     = CW'(1);
            state_nxt = ST_S_RDO;
          end else begin
            state_nxt = ST_R_RDI;
          end
        end else begin
          dens_raddr = j_r[IW-1:0];
          state_nxt  = ST_R_EX;
        end
      end
      ST_R_EX: begin
        if (dens_rdata > di_r || (dens_rdata == di_r && j_r > i_r)) r_nxt = r_r + CW'(1);
        j_nxt     = j_r + CW'(1);
        state_nxt = ST_R_RD;
      end
      ST_S_RDO: begin
        if (r_r == n_r) begin
          state_nxt = ST_S_TOP;
        end else begin
          ord_raddr = r_r[IW-1:0];
          state_nxt = ST_S_LDO;
        end
      end
      ST_S_LDO: begin
        si_nxt    = ord_rdata;
        sepv_nxt  = DIST_MAX;
        nbv_nxt   = '0;
        j_nxt     = '0;
        state_nxt = ST_S_RDJ;
      end
      ST_S_RDJ: begin
        if (j_r == r_r) begin
          sep_we = 1'b1;
          nb_we  = 1'b1;
          if (sepv_r > best_r) best_nxt = sepv_r;
          r_nxt     = r_r + CW'(1);
          state_nxt = ST_S_RDO;
        end else begin
          ord_raddr = j_r[IW-1:0];
          state_nxt = ST_S_RDD;
        end
      end
      ST_S_RDD: begin
        o_nxt      = ord_rdata;
        dist_raddr = daddr(CW'(si_r), CW'(ord_rdata), n_r);
        state_nxt  = ST_S_EX;
      end
      ST_S_EX: begin
        if (dist_rdata < sepv_r) begin
          sepv_nxt = dist_rdata;
          nbv_nxt  = {1'b1, o_r};
        end
        j_nxt     = j_r + CW'(1);
        state_nxt = ST_S_RDJ;
      end
      ST_S_TOP: begin
        ord_raddr = '0;
        state_nxt = ST_S_TOPW;
      end
      ST_S_TOPW: begin
        sep_we    = 1'b1;
        sep_waddr = ord_rdata;
        sep_wdata = best_r;
        nb_we     = 1'b1;
        nb_waddr  = ord_rdata;
        nb_wdata  = '0;
        i_nxt     = '0;
        ncl_nxt   = '0;
        state_nxt = ST_L_RD;
      end
      ST_L_RD: begin
        if (i_r == n_r) begin
          r_nxt     = '0;
          state_nxt = ST_P_RDO;
        end else begin
          dens_raddr = i_r[IW-1:0];
          sep_raddr  = i_r[IW-1:0];
          state_nxt  = ST_L_EX;
        end
      end
      ST_L_EX: begin
        lab_we = 1'b1;
        if (dens_center && sep_center) begin
          lab_wdata = LW'(ncl_r);
          ncl_nxt   = ncl_r + CW'(1);
        end
        i_nxt     = i_r + CW'(1);
        state_nxt = ST_L_RD;
      end
      ST_P_RDO: begin
        if (r_r == n_r) begin
          i_nxt     = '0;
          state_nxt = (ncl_r <= CW'(1)) ? ST_O_RD : ST_H_CLR;
        end else begin
          ord_raddr = r_r[IW-1:0];
          state_nxt = ST_P_RDL;
        end
      end
      ST_P_RDL: begin
        pi_nxt    = ord_rdata;
        lab_raddr = ord_rdata;
        nb_raddr  = ord_rdata;
        state_nxt = ST_P_EX;
      end
      ST_P_EX: begin
        if (lab_rdata == '1 && nb_rdata[IW]) begin
          lab_raddr = nb_rdata[IW-1:0];
          state_nxt = ST_P_WR;
        end else begin
          r_nxt     = r_r + CW'(1);
          state_nxt = ST_P_RDO;
        end
      end
      ST_P_WR: begin
        lab_we    = 1'b1;
        lab_waddr = pi_r;
        lab_wdata = lab_rdata;
        r_nxt     = r_r + CW'(1);
        state_nxt = ST_P_RDO;
      end
      ST_H_CLR: begin
        bord_we    = 1'b1;
        bord_waddr = i_r[IW-1:0];
        bord_wdata = '0;
        if (i_r + CW'(1) == n_r) begin
          i_nxt     = '0;
          state_nxt = ST_H_RDI;
        end else begin
          i_nxt = i_r + CW'(1);
        end
      end
      ST_H_RDI: begin
        lab_raddr  = i_r[IW-1:0];
        dens_raddr = i_r[IW-1:0];
        state_nxt  = ST_H_LDI;
      end
      ST_H_LDI: begin
        li_nxt    = lab_rdata;
        di_nxt    = dens_rdata;
        j_nxt     = i_r + CW'(1);
        state_nxt = ST_H_RDJ;
      end
      ST_H_RDJ: begin
        if (j_r == n_r) begin
          i_nxt = i_r + CW'(1);
          if (i_r + CW'(2) >= n_r) begin
            i_nxt     = '0;
            state_nxt = ST_O_RD;
          end else begin
            state_nxt = ST_H_RDI;
          end
        end else begin
          lab_raddr  = j_r[IW-1:0];
          dens_raddr = j_r[IW-1:0];
          dist_raddr = daddr(i_r, j_r, n_r);
          state_nxt  = ST_H_EX;
        end
      end
      ST_H_EX: begin
        lj_nxt    = lab_rdata;
        avg_nxt   = pair_sum[RHO_W:1];
        j_nxt     = j_r + CW'(1);
        state_nxt = ST_H_RDJ;
        if (li_r != lab_rdata && dist_rdata != DIST_MAX && dist_rdata <= dc_r) begin
          if (!li_r[LW-1]) begin
            j_nxt      = j_r;
            bord_raddr = li_r[IW-1:0];
            state_nxt  = ST_H_BI;
          end else if (!lab_rdata[LW-1]) begin
            j_nxt      = j_r;
            bord_raddr = lab_rdata[IW-1:0];
            state_nxt  = ST_H_BJ;
          end
        end
      end
      ST_H_BI: begin
        if (avg_r > bord_rdata) bord_we = 1'b1;
        if (!lj_r[LW-1]) begin
          bord_raddr = lj_r[IW-1:0];
          state_nxt  = ST_H_BJ;
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = ST_H_RDJ;
        end
      end
      ST_H_BJ: begin
        bord_waddr = lj_r[IW-1:0];
        if (avg_r > bord_rdata) bord_we = 1'b1;
        j_nxt     = j_r + CW'(1);
        state_nxt = ST_H_RDJ;
      end
      ST_O_RD: begin
        lab_raddr  = i_r[IW-1:0];
        dens_raddr = i_r[IW-1:0];
        sep_raddr  = i_r[IW-1:0];
        state_nxt  = ST_O_RDB;
      end
      ST_O_RDB: begin
        lo_lab_nxt = lab_rdata;
        di_nxt     = dens_rdata;
        cen_nxt    = dens_center && sep_center;
        bord_raddr = lab_rdata[IW-1:0];
        state_nxt  = ST_O_EX;
      end
      ST_O_EX: begin
        ov_nxt    = 1'b1;
        oidx_nxt  = i_r[IW-1:0];
        olab_nxt  = lo_lab_r;
        ocen_nxt  = cen_r;
        ocore_nxt = !lo_lab_r[LW-1] && (ncl_r <= CW'(1) || !(di_r < bord_rdata));
        olast_nxt = (i_r + CW'(1) == n_r);
        state_nxt = ST_O_WAIT;
      end
      ST_O_WAIT: begin
        if (!out_stall) begin
          ov_nxt = 1'b0;
          i_nxt  = i_r + CW'(1);
          state_nxt = olast_r ? ST_IDLE : ST_O_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      ov_r          <= 1'b0;
      lp_r          <= '0;
      num_samples_r <= NUM_SAMPLES_RST;
      kernel_mode_r <= 1'b0;
      rho_min_r     <= RHO_MIN_RST;
      delta_min_r   <= DELTA_MIN_RST;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (in_acc) begin
        if (in_last_element || lp_r == SAW'(DEPTH - 1)) lp_r <= '0;
        else lp_r <= lp_r + SAW'(1);
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_NUM_SAMPLES: num_samples_r <= cfg_wdata[6:0];
          CFG_KERNEL_MODE: kernel_mode_r <= cfg_wdata[0];
          CFG_RHO_MIN:     rho_min_r     <= cfg_wdata[RHO_W-1:0];
          CFG_DELTA_MIN:   delta_min_r   <= cfg_wdata[15:0];
          default:         ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    r_r      <= r_nxt;
    ncl_r    <= ncl_nxt;
    x_r      <= x_nxt;
    k_r      <= k_nxt;
    cnt_r    <= cnt_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    dc_r     <= dc_nxt;
    d_r      <= d_nxt;
    sepv_r   <= sepv_nxt;
    best_r   <= best_nxt;
    acc_r    <= acc_nxt;
    di_r     <= di_nxt;
    avg_r    <= avg_nxt;
    q_r      <= q_nxt;
    t_r      <= t_nxt;
    si_r     <= si_nxt;
    o_r      <= o_nxt;
    pi_r     <= pi_nxt;
    nbv_r    <= nbv_nxt;
    li_r     <= li_nxt;
    lj_r     <= lj_nxt;
    lo_lab_r <= lo_lab_nxt;
    cen_r    <= cen_nxt;
    oidx_r   <= oidx_nxt;
    olab_r   <= olab_nxt;
    ocen_r   <= ocen_nxt;
    ocore_r  <= ocore_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_valid         = ov_r;
  assign out_sample_index  = oidx_r;
  assign out_cluster_id    = olab_r;
  assign out_is_center     = ocen_r;
  assign out_is_core       = ocore_r;
  assign out_cluster_count = ncl_r;
  assign out_last_result   = olast_r;

  dpc_ram #(.WIDTH(DIST_BITS), .DEPTH(DEPTH)) u_dist_ram (
    .clk(clk), .we(in_acc), .waddr(lp_r), .wdata(in_distance),
    .raddr(dist_raddr), .rdata(dist_rdata)
  );

  dpc_ram #(.WIDTH(RHO_W), .DEPTH(MAX_SAMPLES)) u_dens_ram (
    .clk(clk), .we(dens_we), .waddr(dens_waddr), .wdata(dens_wdata),
    .raddr(dens_raddr), .rdata(dens_rdata)
  );

  dpc_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_SAMPLES)) u_sep_ram (
    .clk(clk), .we(sep_we), .waddr(sep_waddr), .wdata(sep_wdata),
    .raddr(sep_raddr), .rdata(sep_rdata)
  );

  dpc_ram #(.WIDTH(IW + 1), .DEPTH(MAX_SAMPLES)) u_nb_ram (
    .clk(clk), .we(nb_we), .waddr(nb_waddr), .wdata(nb_wdata),
    .raddr(nb_raddr), .rdata(nb_rdata)
  );

  dpc_ram #(.WIDTH(LW), .DEPTH(MAX_SAMPLES)) u_lab_ram (
    .clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
    .raddr(lab_raddr), .rdata(lab_rdata)
  );

  dpc_ram #(.WIDTH(IW), .DEPTH(MAX_SAMPLES)) u_ord_ram (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rdata)
  );

  dpc_ram #(.WIDTH(RHO_W), .DEPTH(MAX_SAMPLES)) u_bord_ram (
    .clk(clk), .we(bord_we), .waddr(bord_waddr), .wdata(bord_wdata),
    .raddr(bord_raddr), .rdata(bord_rdata)
  );

endmodule
